>>> rtl/cdoc_pkg.sv
// ----------------------------------------------------------------------------
// cdoc_pkg
// Shared types, constants and calendar tables for the Gregorian date
// converter: mode codes, stream widths and month length lookups.
// ----------------------------------------------------------------------------
package cdoc_pkg;

    // Operation selector carried on s_axis_tuser; the spare code acts as a date check
    typedef enum logic [1:0] {
        MODE_CHECK      = 2'd0,
        MODE_ORDINAL    = 2'd1,
        MODE_SHORT_YEAR = 2'd2
    } t_mode;

    // Stream widths (fields packed from bit 0, zero filled to whole bytes)
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 48;

    // Calendar constants
    localparam logic [14:0] YEAR_DEFAULT  = 15'd1900;
    localparam logic [14:0] CENTURY_19    = 15'd1900;
    localparam logic [14:0] CENTURY_20    = 15'd2000;
    localparam logic [6:0]  SHORT_PIVOT   = 7'd50;
    localparam logic [6:0]  SHORT_MAX     = 7'd99;
    localparam logic [8:0]  YEAR_LEN      = 9'd365;
    localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;

    // floor(y / 100) = (y * 5243) >> 19, exact for every 15-bit y
    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam int unsigned RECIP_SHIFT   = 19;
    localparam logic [15:0] HUNDRED       = 16'd100;

    // Days in a month; zero for a month number outside 1..12
    function automatic logic [4:0] f_month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     days = 5'd30;
            4'd2:                                        days = leap ? 5'd29 : 5'd28;
            default:                                     days = 5'd0;
        endcase
        return days;
    endfunction

    // Days in the year before the first of the month (month 13 gives the year length)
    function automatic logic [8:0] f_days_before(input logic [3:0] month, input logic leap);
        logic [8:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            4'd13:   days = 9'd365;
            default: days = 9'd0;
        endcase
        if (leap && (month > 4'd2) && (month < 4'd14)) begin
            days = days + 9'd1;
        end
        return days;
    endfunction

endpackage

>>> rtl/calendar_date_ordinal_converter_core.sv
// ----------------------------------------------------------------------------
// calendar_date_ordinal_converter_core
// Gregorian date converter: date check and repair, ordinal day to month/day,
// and two-digit year expansion, one result beat per input beat.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and returns one
// result beat per input beat, in order. The three stages are the input
// register, a stage that holds the year and its quotient by 100 (the
// reciprocal multiply), and the result register. A stalled output holds the
// pipe; up to three beats sit inside. Mode 0 (and the spare mode 3) checks a
// date, mode 1 turns an ordinal day into month/day, mode 2 expands a
// two-digit year (51..99 to 19xx, else 20xx) then checks. Bad parts are
// replaced (year 1900, month 1, day 1) with a flag for each.
module calendar_date_ordinal_converter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] day_in, [9:6] month_in, [25:10] year_in, [34:26] ordinal_in
    input  logic [cdoc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [cdoc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [14:0] year_out, [18:15] month_out, [23:19] day_out, [32:24] ordinal_out,
    // [39:33] short_year, [40] leap, [41] year_fixed, [42] month_fixed,
    // [43] day_fixed, [44] ordinal_bad
    output logic [cdoc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import cdoc_pkg::*;

    // Stage enables: a stage loads when it is empty or its contents move on
    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    assign w_en3         = !r_v3 || m_axis_tready;
    assign w_en2         = !r_v2 || w_en3;
    assign w_en1         = !r_v1 || w_en2;
    assign s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic [1:0]  r_s1_mode;
    logic [5:0]  r_s1_day;
    logic [3:0]  r_s1_month;
    logic [15:0] r_s1_year;
    logic [8:0]  r_s1_ord;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_mode  <= s_axis_tuser[1:0];
            r_s1_day   <= s_axis_tdata[5:0];
            r_s1_month <= s_axis_tdata[9:6];
            r_s1_year  <= s_axis_tdata[25:10];
            r_s1_ord   <= s_axis_tdata[34:26];
        end
    end

    // Year selection and repair
    logic        w_yneg;
    logic        w_short_ok;
    logic [14:0] w_year;
    logic        w_yfix;
    logic [27:0] w_prod;

    assign w_yneg     = r_s1_year[15];
    assign w_short_ok = !w_yneg && (r_s1_year[14:0] <= 15'(SHORT_MAX));

    always_comb begin
        case (r_s1_mode)
            MODE_SHORT_YEAR: begin
                if (w_short_ok) begin
                    w_year = ((r_s1_year[6:0] > SHORT_PIVOT) ? CENTURY_19 : CENTURY_20)
                             + 15'(r_s1_year[6:0]);
                    w_yfix = 1'b0;
                end else begin
                    w_year = YEAR_DEFAULT;
                    w_yfix = 1'b1;
                end
            end
            default: begin
                w_year = w_yneg ? YEAR_DEFAULT : r_s1_year[14:0];
                w_yfix = w_yneg;
            end
        endcase
    end

    // Quotient by 100 through the reciprocal
    assign w_prod = 28'(w_year) * 28'(RECIP_100);

    // ---------------- stage 2: year and quotient ----------------
    logic [1:0]  r_s2_mode;
    logic [5:0]  r_s2_day;
    logic [3:0]  r_s2_month;
    logic [8:0]  r_s2_ord;
    logic [14:0] r_s2_year;
    logic        r_s2_yfix;
    logic [8:0]  r_s2_quot;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_mode  <= r_s1_mode;
            r_s2_day   <= r_s1_day;
            r_s2_month <= r_s1_month;
            r_s2_ord   <= r_s1_ord;
            r_s2_year  <= w_year;
            r_s2_yfix  <= w_yfix;
            r_s2_quot  <= w_prod[RECIP_SHIFT +: 9];
        end
    end

    // Remainder by 100 and leap flag
    logic [15:0] w_rem_full;
    logic [6:0]  w_short;
    logic        w_leap;

    assign w_rem_full = 16'(r_s2_year) - 16'(r_s2_quot) * HUNDRED;
    assign w_short    = w_rem_full[6:0];
    // century years are leap only when the century count divides by four
    assign w_leap     = (w_short == 7'd0) ? (r_s2_quot[1:0] == 2'd0)
                                          : (r_s2_year[1:0] == 2'd0);

    // Ordinal to month: find the first month whose end reaches the ordinal
    logic [8:0]  w_ylen;
    logic        w_obad;
    logic [3:0]  w_omonth;
    logic [8:0]  w_oday;

    assign w_ylen = w_leap ? LEAP_YEAR_LEN : YEAR_LEN;
    assign w_obad = (r_s2_ord == 9'd0) || (r_s2_ord > w_ylen);

    always_comb begin
        w_omonth = 4'd12;
        for (int m = 11; m >= 1; m--) begin
            if (r_s2_ord <= f_days_before(4'(m + 1), w_leap)) begin
                w_omonth = 4'(m);
            end
        end
    end

    assign w_oday = r_s2_ord - f_days_before(w_omonth, w_leap);

    // Date check and repair
    logic        w_mok;
    logic [3:0]  w_cmonth;
    logic [4:0]  w_mdays;
    logic        w_dok;
    logic [4:0]  w_cday;
    logic [8:0]  w_cord;

    assign w_mok    = (r_s2_month >= 4'd1) && (r_s2_month <= 4'd12);
    assign w_cmonth = w_mok ? r_s2_month : 4'd1;
    assign w_mdays  = f_month_days(w_cmonth, w_leap);
    assign w_dok    = (r_s2_day >= 6'd1) && (r_s2_day <= 6'(w_mdays));
    assign w_cday   = w_dok ? r_s2_day[4:0] : 5'd1;
    assign w_cord   = f_days_before(w_cmonth, w_leap) + 9'(w_cday);

    // Result selection per mode
    logic [3:0] n_month;
    logic [4:0] n_day;
    logic [8:0] n_ord;
    logic       n_mfix, n_dfix, n_obad;

    always_comb begin
        case (r_s2_mode)
            MODE_ORDINAL: begin
                n_month = w_obad ? 4'd1 : w_omonth;
                n_day   = w_obad ? 5'd1 : w_oday[4:0];
                n_ord   = w_obad ? 9'd1 : r_s2_ord;
                n_mfix  = 1'b0;
                n_dfix  = 1'b0;
                n_obad  = w_obad;
            end
            default: begin
                n_month = w_cmonth;
                n_day   = w_cday;
                n_ord   = w_cord;
                n_mfix  = !w_mok;
                n_dfix  = !w_dok;
                n_obad  = 1'b0;
            end
        endcase
    end

    // ---------------- stage 3: result register ----------------
    logic [14:0] r_s3_year;
    logic [3:0]  r_s3_month;
    logic [4:0]  r_s3_day;
    logic [8:0]  r_s3_ord;
    logic [6:0]  r_s3_short;
    logic        r_s3_leap, r_s3_yfix, r_s3_mfix, r_s3_dfix, r_s3_obad;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_year  <= r_s2_year;
            r_s3_month <= n_month;
            r_s3_day   <= n_day;
            r_s3_ord   <= n_ord;
            r_s3_short <= w_short;
            r_s3_leap  <= w_leap;
            r_s3_yfix  <= r_s2_yfix;
            r_s3_mfix  <= n_mfix;
            r_s3_dfix  <= n_dfix;
            r_s3_obad  <= n_obad;
        end
    end

    assign m_axis_tvalid = r_v3;

    assign m_axis_tdata = {3'b000, r_s3_obad, r_s3_dfix, r_s3_mfix, r_s3_yfix, r_s3_leap,
                           r_s3_short, r_s3_ord, r_s3_day, r_s3_month, r_s3_year};

endmodule

>>> rtl/cdoc_checker.sv
// ----------------------------------------------------------------------------
// cdoc_checker
// Port-level checks for the date converter, bound to the top level.
// ----------------------------------------------------------------------------
module cdoc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [cdoc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [cdoc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [cdoc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import cdoc_pkg::*;

    logic       w_in_beat, w_out_beat;
    logic [1:0] r_inflight, n_inflight;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_beat = m_axis_tvalid && m_axis_tready;

    // Beats accepted but not yet delivered
    always_comb begin
        n_inflight = r_inflight;
        if (w_in_beat && !w_out_beat) n_inflight = r_inflight + 2'd1;
        if (!w_in_beat && w_out_beat) n_inflight = r_inflight - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 2'd0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // No result beat without an accepted beat behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_inflight != 2'd0))
        else $error("result beat without accepted input");

    // The pipe holds at most three beats
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_inflight == 2'd3) && w_in_beat && !w_out_beat))
        else $error("more beats accepted than the pipe holds");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

    // Repaired fields stay in range
    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[18:15] != 4'd0) && (m_axis_tdata[18:15] <= 4'd12)
                           && (m_axis_tdata[23:19] != 5'd0) && (m_axis_tdata[32:24] != 9'd0)
                           && (m_axis_tdata[39:33] <= 7'd99)))
        else $error("result field out of range");

    // A bad ordinal gives January 1 and no date repair flags
    a_bad_ordinal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[44]) |->
            ((m_axis_tdata[18:15] == 4'd1) && (m_axis_tdata[23:19] == 5'd1)
             && (m_axis_tdata[32:24] == 9'd1) && !m_axis_tdata[42] && !m_axis_tdata[43]))
        else $error("bad ordinal result is not January 1");

endmodule

bind calendar_date_ordinal_converter_core cdoc_checker u_cdoc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
